### sv/speed_pi_antiwindup_macros.svh
// Assertion macros for the speed PI controller with anti-windup.
`ifndef SPEED_PI_ANTIWINDUP_MACROS_SVH
`define SPEED_PI_ANTIWINDUP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on clk, off during reset.
`define SPAW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("speed_pi_antiwindup: check failed");

// Next-cycle implication, checked on clk, off during reset.
`define SPAW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("speed_pi_antiwindup: check failed");

`else

`define SPAW_ASSERT_IMP(lbl, ante, cons)
`define SPAW_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### sv/spaw_pkg.sv
// Widths, constants and register indexes of the speed PI controller.
package spaw_pkg;

  // Port widths
  localparam int CNT_IN_W   = 16;
  localparam int TILT_W     = 17;
  localparam int GAIN_W     = 32;
  localparam int LIM_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Internal datapath widths
  localparam int FILT_W     = 24;
  localparam int SUM_W      = 48;
  localparam int ERR_W      = 25;
  localparam int P_W        = 33;
  localparam int FRAC       = 24;
  localparam int FILT_SHIFT = 16;
  localparam int ACC_W      = 82;
  localparam int TOT_W      = ACC_W - FRAC;
  localparam int DQ_W       = GAIN_W + FRAC;
  localparam int CNT_W      = 6;
  localparam int MUL_STEPS  = GAIN_W;
  localparam int DIV_STEPS  = DQ_W;

  // Filter coefficients in Q16: 0.3 new, 0.7 old
  localparam logic [GAIN_W-1:0] COEF_NEW = 32'd19661;
  localparam logic [GAIN_W-1:0] COEF_OLD = 32'd45875;

  // Rounding offsets preloaded into the accumulator
  localparam logic [ACC_W-1:0] FILT_ROUND = ACC_W'(32768);
  localparam logic [ACC_W-1:0] Q24_ROUND  = ACC_W'(8388608);
  localparam logic [FRAC-1:0]  Q24_HALF   = FRAC'(8388608);

  // Saturation bounds
  localparam logic [FILT_W-1:0] FILT_MAX = 24'h7FFFFF;
  localparam logic [FILT_W-1:0] FILT_MIN = 24'h800000;
  localparam logic [SUM_W-1:0]  SUM_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0]  SUM_MIN  = 48'h8000_0000_0000;

  // Integral gains below this magnitude skip back-calculation
  localparam logic signed [GAIN_W-1:0] KI_TINY   = 32'sd1678;
  localparam logic signed [GAIN_W-1:0] KI_TINY_N = -32'sd1678;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST   = 32'hFFE6_6666;
  localparam logic [GAIN_W-1:0] GAIN_I_RST   = 32'hFFFF_EC57;
  localparam logic [LIM_W-1:0]  FALL_THR_RST = 16'd10240;
  localparam logic [LIM_W-1:0]  MAX_TILT_RST = 16'd2560;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_THR = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TILT = 4'd3;

endpackage

### sv/speed_pi_antiwindup.sv
// Speed-loop PI controller with back-calculation anti-windup, one shared adder.
//
// Input channel (in_valid/in_ready): one request per control tick carrying both
// encoder counts, the tilt angle and the speed goal. Result channel
// (out_valid/out_ready): the target tilt and the sticky fall flag.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 gain_p, 1 gain_i,
// 2 fall_threshold, 3 max_tilt; other indexes are ignored.
//
// The sums and products run through one 82-bit adder under a sequencer: each of the
// five products is a 32-step shift-add, and the back-calculation divide is a
// 56-step restoring divide. in_ready is high only while the sequencer is idle,
// so a new request is not accepted until the previous result has been handed to
// the output register.
//
// The result sits in an output register, so a new request is accepted while
// it waits; a finished result then holds in the sequencer until the output
// register frees up. Reset (rst_n low at a clock edge) clears the filter,
// integrator and fall flag, drops out_valid and restores register defaults.
module speed_pi_antiwindup (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [spaw_pkg::CNT_IN_W-1:0]   in_count_left,
  input  logic signed [spaw_pkg::CNT_IN_W-1:0]   in_count_right,
  input  logic signed [spaw_pkg::TILT_W-1:0]     in_tilt_angle,
  input  logic signed [spaw_pkg::CNT_IN_W-1:0]   in_speed_goal,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [spaw_pkg::TILT_W-1:0]     out_target_tilt,
  output logic                                   out_fallen,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [spaw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [spaw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spaw_pkg::*;

`include "speed_pi_antiwindup_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE, S_AVG, S_FMUL0, S_FMUL1, S_FILT, S_ERR, S_PMUL, S_NEXT, S_IMUL1,
    S_CHK, S_DSUB, S_DABS, S_DIV, S_DFIX, S_RES, S_IMUL2, S_CLAMP, S_DONE
  } state_t;

  // Config registers
  logic [GAIN_W-1:0] gain_p_r, gain_i_r;
  logic [LIM_W-1:0]  fall_thr_r, max_tilt_r;

  // Control and persistent state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FILT_W-1:0] filt_r, filt_nxt;
  logic [SUM_W-1:0]  es_r, es_nxt;
  logic              fall_r, fall_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [CNT_IN_W-1:0] cl_r, cr_r, goal_r;
  logic [TILT_W-1:0]   tilt_r;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ACC_W-1:0]    mc_r, mc_nxt;
  logic [GAIN_W-1:0]   mplier_r, mplier_nxt;
  logic [ERR_W-1:0]    err_r, err_nxt;
  logic [P_W-1:0]      p_r, p_nxt;
  logic [SUM_W-1:0]    next_r, next_nxt;
  logic [TILT_W-1:0]   edge_r, edge_nxt;
  logic [GAIN_W-1:0]   dvs_r, dvs_nxt;
  logic                gneg_r, gneg_nxt;
  logic                qneg_r, qneg_nxt;
  logic [GAIN_W-1:0]   rem_r, rem_nxt;
  logic [DQ_W-1:0]     dq_r, dq_nxt;
  logic [TILT_W-1:0]   res_r, res_nxt;
  logic [TILT_W-1:0]   out_tilt_r, out_tilt_nxt;
  logic                out_fallen_r, out_fallen_nxt;

  // Shared adder
  logic [ACC_W-1:0] add_a, add_b, add_sum;
  logic             add_sub;

  // Helpers
  logic                    mul_last, div_last;
  logic [ACC_W-1:0]        acc_step, mc_step;
  logic [GAIN_W-1:0]       mplier_step;
  logic [FILT_W-1:0]       filt_sat;
  logic [SUM_W-1:0]        next_sat;
  logic [ACC_W-FILT_SHIFT-FILT_W:0] filt_top;
  logic [ACC_W-SUM_W:0]    sum_top;
  logic signed [TOT_W-1:0] tot_s, lim_s, lim_n;
  logic                    over, under, big, fall_hit;
  logic [TILT_W-1:0]       tilt_mag;
  logic [GAIN_W-1:0]       gi_mag, dabs_mag;
  logic                    div_ok;

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_target_tilt = out_tilt_r;
  assign out_fallen      = out_fallen_r;

  // Operand select for the shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      S_AVG: begin
        add_a = {{(ACC_W-CNT_IN_W){cl_r[CNT_IN_W-1]}}, cl_r};
        add_b = {{(ACC_W-CNT_IN_W){cr_r[CNT_IN_W-1]}}, cr_r};
      end
      S_FMUL0, S_FMUL1, S_PMUL, S_IMUL1, S_IMUL2: begin
        add_a   = acc_r;
        add_b   = mc_r;
        add_sub = mul_last;
      end
      S_ERR: begin
        add_a   = {{(ACC_W-CNT_IN_W-8){goal_r[CNT_IN_W-1]}}, goal_r, 8'h00};
        add_b   = {{(ACC_W-FILT_W){filt_r[FILT_W-1]}}, filt_r};
        add_sub = 1'b1;
      end
      S_NEXT: begin
        add_a = {{(ACC_W-SUM_W){es_r[SUM_W-1]}}, es_r};
        add_b = {{(ACC_W-ERR_W){err_r[ERR_W-1]}}, err_r};
      end
      S_DSUB: begin
        add_a   = {{(ACC_W-TILT_W){edge_r[TILT_W-1]}}, edge_r};
        add_b   = {{(ACC_W-P_W){p_r[P_W-1]}}, p_r};
        add_sub = 1'b1;
      end
      S_DABS: begin
        add_b   = acc_r;
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = {{(ACC_W-GAIN_W-1){1'b0}}, rem_r, dq_r[DQ_W-1]};
        add_b   = {{(ACC_W-GAIN_W){1'b0}}, dvs_r};
        add_sub = 1'b1;
      end
      S_DFIX: begin
        add_b   = {{(ACC_W-DQ_W){1'b0}}, dq_r};
        add_sub = qneg_r;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(ACC_W-1){1'b0}}, add_sub};

  // Shift-add step: add (or subtract at the sign bit) the shifted multiplicand
  assign mul_last    = (cnt_r == CNT_W'(MUL_STEPS-1));
  assign div_last    = (cnt_r == CNT_W'(DIV_STEPS-1));
  assign acc_step    = mplier_r[0] ? add_sum : acc_r;
  assign mc_step     = {mc_r[ACC_W-2:0], 1'b0};
  assign mplier_step = {1'b0, mplier_r[GAIN_W-1:1]};

  // Filter saturation from the accumulator
  assign filt_top = acc_r[ACC_W-1:FILT_SHIFT+FILT_W-1];
  assign filt_sat = ((&filt_top) || !(|filt_top)) ?
                    acc_r[FILT_SHIFT+FILT_W-1:FILT_SHIFT] :
                    (acc_r[ACC_W-1] ? FILT_MIN : FILT_MAX);

  // Integral saturation from the adder
  assign sum_top  = add_sum[ACC_W-1:SUM_W-1];
  assign next_sat = ((&sum_top) || !(|sum_top)) ? add_sum[SUM_W-1:0] :
                    (add_sum[ACC_W-1] ? SUM_MIN : SUM_MAX);

  // Limit checks on the Q24 total
  assign tot_s = $signed(acc_r[ACC_W-1:FRAC]);
  assign lim_s = $signed({{(TOT_W-LIM_W){1'b0}}, max_tilt_r});
  assign lim_n = -lim_s;
  assign over  = (tot_s > lim_s);
  assign under = (tot_s < lim_n);
  assign big   = ($signed(gain_i_r) >= KI_TINY) || ($signed(gain_i_r) <= KI_TINY_N);
  assign gi_mag = gain_i_r[GAIN_W-1] ? (~gain_i_r + GAIN_W'(1)) : gain_i_r;

  // Fall detection
  assign tilt_mag = tilt_r[TILT_W-1] ? (~tilt_r + TILT_W'(1)) : tilt_r;
  assign fall_hit = (tilt_mag > {{(TILT_W-LIM_W){1'b0}}, fall_thr_r});

  // Divider helpers
  assign dabs_mag = acc_r[ACC_W-1] ? add_sum[GAIN_W-1:0] : acc_r[GAIN_W-1:0];
  assign div_ok   = !add_sum[ACC_W-1];

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    filt_nxt       = filt_r;
    es_nxt         = es_r;
    fall_nxt       = fall_r;
    out_valid_nxt  = out_valid_r;
    acc_nxt        = acc_r;
    mc_nxt         = mc_r;
    mplier_nxt     = mplier_r;
    err_nxt        = err_r;
    p_nxt          = p_r;
    next_nxt       = next_r;
    edge_nxt       = edge_r;
    dvs_nxt        = dvs_r;
    gneg_nxt       = gneg_r;
    qneg_nxt       = qneg_r;
    rem_nxt        = rem_r;
    dq_nxt         = dq_r;
    res_nxt        = res_r;
    out_tilt_nxt   = out_tilt_r;
    out_fallen_nxt = out_fallen_r;

    // Result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_AVG;
        end
      end
      // average, scaled to 8 fraction bits; start 0.3 * avg
      S_AVG: begin
        acc_nxt    = FILT_ROUND;
        mc_nxt     = {add_sum[ACC_W-8:0], 7'b0};
        mplier_nxt = COEF_NEW;
        cnt_nxt    = '0;
        state_nxt  = S_FMUL0;
      end
      S_FMUL0: begin
        acc_nxt    = acc_step;
        mc_nxt     = mc_step;
        mplier_nxt = mplier_step;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (mul_last) begin
          mc_nxt     = {{(ACC_W-FILT_W){filt_r[FILT_W-1]}}, filt_r};
          mplier_nxt = COEF_OLD;
          cnt_nxt    = '0;
          state_nxt  = S_FMUL1;
        end
      end
      S_FMUL1: begin
        acc_nxt    = acc_step;
        mc_nxt     = mc_step;
        mplier_nxt = mplier_step;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (mul_last) begin
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        filt_nxt  = filt_sat;
        state_nxt = S_ERR;
      end
      // speed error; fall check
      S_ERR: begin
        err_nxt = add_sum[ERR_W-1:0];
        if (fall_hit) begin
          es_nxt    = '0;
          fall_nxt  = 1'b1;
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          acc_nxt    = Q24_ROUND;
          mc_nxt     = add_sum;
          mplier_nxt = gain_p_r;
          cnt_nxt    = '0;
          state_nxt  = S_PMUL;
        end
      end
      S_PMUL: begin
        acc_nxt    = acc_step;
        mc_nxt     = mc_step;
        mplier_nxt = mplier_step;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (mul_last) begin
          state_nxt = S_NEXT;
        end
      end
      // latch P, form saturated integral, preload P into the I product
      S_NEXT: begin
        p_nxt      = acc_r[FRAC+P_W-1:FRAC];
        next_nxt   = next_sat;
        acc_nxt    = {{(ACC_W-FRAC-P_W){acc_r[FRAC+P_W-1]}},
                      acc_r[FRAC+P_W-1:FRAC], Q24_HALF};
        mc_nxt     = {{(ACC_W-SUM_W){next_sat[SUM_W-1]}}, next_sat};
        mplier_nxt = gain_i_r;
        cnt_nxt    = '0;
        state_nxt  = S_IMUL1;
      end
      S_IMUL1: begin
        acc_nxt    = acc_step;
        mc_nxt     = mc_step;
        mplier_nxt = mplier_step;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (mul_last) begin
          state_nxt = S_CHK;
        end
      end
      // overflow check on P + I(next)
      S_CHK: begin
        if (over || under) begin
          if (big) begin
            edge_nxt  = over ? lim_s[TILT_W-1:0] : lim_n[TILT_W-1:0];
            dvs_nxt   = gi_mag;
            gneg_nxt  = gain_i_r[GAIN_W-1];
            state_nxt = S_DSUB;
          end else begin
            es_nxt    = '0;
            state_nxt = S_RES;
          end
        end else begin
          es_nxt    = next_r;
          state_nxt = S_RES;
        end
      end
      S_DSUB: begin
        acc_nxt   = add_sum;
        state_nxt = S_DABS;
      end
      // magnitude of (edge - P) * 2^24 into the dividend
      S_DABS: begin
        dq_nxt    = {dabs_mag, {FRAC{1'b0}}};
        qneg_nxt  = acc_r[ACC_W-1] ^ gneg_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        rem_nxt = div_ok ? add_sum[GAIN_W-1:0] : {rem_r[GAIN_W-2:0], dq_r[DQ_W-1]};
        dq_nxt  = {dq_r[DQ_W-2:0], div_ok};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_last) begin
          state_nxt = S_DFIX;
        end
      end
      // quotient sign; magnitude stays below 2^46
      S_DFIX: begin
        es_nxt    = add_sum[SUM_W-1:0];
        state_nxt = S_RES;
      end
      S_RES: begin
        acc_nxt    = {{(ACC_W-FRAC-P_W){p_r[P_W-1]}}, p_r, Q24_HALF};
        mc_nxt     = {{(ACC_W-SUM_W){es_r[SUM_W-1]}}, es_r};
        mplier_nxt = gain_i_r;
        cnt_nxt    = '0;
        state_nxt  = S_IMUL2;
      end
      S_IMUL2: begin
        acc_nxt    = acc_step;
        mc_nxt     = mc_step;
        mplier_nxt = mplier_step;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (mul_last) begin
          state_nxt = S_CLAMP;
        end
      end
      // hard clamp to +-max_tilt
      S_CLAMP: begin
        if (over) begin
          res_nxt = lim_s[TILT_W-1:0];
        end else if (under) begin
          res_nxt = lim_n[TILT_W-1:0];
        end else begin
          res_nxt = tot_s[TILT_W-1:0];
        end
        state_nxt = S_DONE;
      end
      // hand over once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_tilt_nxt   = res_r;
          out_fallen_nxt = fall_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, config and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      filt_r      <= '0;
      es_r        <= '0;
      fall_r      <= 1'b0;
      out_valid_r <= 1'b0;
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      fall_thr_r  <= FALL_THR_RST;
      max_tilt_r  <= MAX_TILT_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      filt_r      <= filt_nxt;
      es_r        <= es_nxt;
      fall_r      <= fall_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:   gain_p_r   <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I:   gain_i_r   <= cfg_data[GAIN_W-1:0];
          REG_FALL_THR: fall_thr_r <= cfg_data[LIM_W-1:0];
          REG_MAX_TILT: max_tilt_r <= cfg_data[LIM_W-1:0];
          default: begin
          end
        endcase
      end
    end

    // capture request payload
    if (in_valid && in_ready) begin
      cl_r   <= in_count_left;
      cr_r   <= in_count_right;
      tilt_r <= in_tilt_angle;
      goal_r <= in_speed_goal;
    end

    acc_r        <= acc_nxt;
    mc_r         <= mc_nxt;
    mplier_r     <= mplier_nxt;
    err_r        <= err_nxt;
    p_r          <= p_nxt;
    next_r       <= next_nxt;
    edge_r       <= edge_nxt;
    dvs_r        <= dvs_nxt;
    gneg_r       <= gneg_nxt;
    qneg_r       <= qneg_nxt;
    rem_r        <= rem_nxt;
    dq_r         <= dq_nxt;
    res_r        <= res_nxt;
    out_tilt_r   <= out_tilt_nxt;
    out_fallen_r <= out_fallen_nxt;
  end

  // Checks
  `SPAW_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SPAW_ASSERT_NXT(a_fall_sticky, fall_r, fall_r)
  `SPAW_ASSERT_IMP(a_div_rem_bound, state_r == S_DIV, rem_r < dvs_r)
  `SPAW_ASSERT_NXT(a_out_drop, out_valid && out_ready && state_r != S_DONE, !out_valid)

endmodule
